>>> sv/tcpsp_pkg.sv
// ----------------------------------------------------------------------------
// tcpsp_pkg
// Shared types and constants of the TCP segment parser and checksum block.
// ----------------------------------------------------------------------------
package tcpsp_pkg;

	localparam logic [7:0]  TCP_PROTO     = 8'h06;
	localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
	localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;
	localparam logic [15:0] MAX_COUNT     = 16'hFFFF;
	localparam logic [5:0]  OPT_CNT_MAX   = 6'd63;
	localparam logic [7:0]  OPT_LEN_MIN   = 8'd2;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SHORT  = 2'd1;
	localparam logic [1:0] ST_BADHDR = 2'd2;

	// plain sum of segment words, at most 32767 words of 16 bits
	localparam int DSUM_W = 31;
	// plain sum of the four pseudo-header address words
	localparam int PSUM_W = 18;

	typedef struct packed {
		logic [7:0]  seg_byte;
		logic        first_byte;
		logic        last_byte;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
	} seg_word_t;

	// everything the walker hands over at the last byte of a segment
	typedef struct packed {
		logic [15:0]       n;
		logic [DSUM_W-1:0] data_sum;
		logic [PSUM_W-1:0] pseudo_sum;
		logic [7:0]        hold;
		logic [31:0]       ports;
		logic [31:0]       seq_num;
		logic [31:0]       ack_num;
		logic [3:0]        header_words;
		logic [7:0]        flag_bits;
		logic [15:0]       window;
		logic [15:0]       urgent_ptr;
		logic [5:0]        option_count;
	} fin_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] seq_num;
		logic [31:0] ack_num;
		logic [3:0]  header_words;
		logic [7:0]  flag_bits;
		logic [15:0] window;
		logic [15:0] urgent_ptr;
		logic [5:0]  option_count;
		logic [15:0] payload_length;
		logic [15:0] computed_checksum;
	} res_t;

endpackage

>>> sv/tcpsp_seg_if.sv
// ----------------------------------------------------------------------------
// tcpsp_seg_if
// Byte channel into the parser: one segment byte per word plus side data.
// ----------------------------------------------------------------------------
interface tcpsp_seg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  seg_byte;
	logic        first_byte;
	logic        last_byte;
	logic [31:0] src_ip;
	logic [31:0] dst_ip;

	modport source (
		output valid, seg_byte, first_byte, last_byte, src_ip, dst_ip,
		input  ready
	);
	modport sink (
		input  valid, seg_byte, first_byte, last_byte, src_ip, dst_ip,
		output ready
	);
endinterface

>>> sv/tcpsp_res_if.sv
// ----------------------------------------------------------------------------
// tcpsp_res_if
// Result channel of the parser: one parsed header summary per word.
// ----------------------------------------------------------------------------
interface tcpsp_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [31:0] seq_num;
	logic [31:0] ack_num;
	logic [3:0]  header_words;
	logic [7:0]  flag_bits;
	logic [15:0] window;
	logic [15:0] urgent_ptr;
	logic [5:0]  option_count;
	logic [15:0] payload_length;
	logic [15:0] computed_checksum;

	modport source (
		output valid, status, src_port, dst_port, seq_num, ack_num, header_words,
		       flag_bits, window, urgent_ptr, option_count, payload_length,
		       computed_checksum,
		input  ready
	);
	modport sink (
		input  valid, status, src_port, dst_port, seq_num, ack_num, header_words,
		       flag_bits, window, urgent_ptr, option_count, payload_length,
		       computed_checksum,
		output ready
	);
endinterface

>>> sv/tcp_segment_parse_checksum.sv
// ----------------------------------------------------------------------------
// tcp_segment_parse_checksum
// Parses a TCP segment taken one byte per word and computes its Internet
// checksum over the IPv4 pseudo-header; one result word per segment.
// ----------------------------------------------------------------------------
// Throughput: one segment byte per cycle while the result path does not stall, no gaps between segments.
// Result path: the last byte and its result pass through the input register,
//   sum/grade stage, fold stage and two-entry output buffer, in that order.
// Reset: arst_n clears all handshake and per-segment control state; the next byte
//   starts a segment with zero addresses unless it carries the first mark.
module tcp_segment_parse_checksum
	import tcpsp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	tcpsp_seg_if.sink  seg,
	tcpsp_res_if.source res
);

	logic fin_valid, fin_ready;
	fin_t fin;
	logic res_valid, res_ready;
	res_t res_d;

	logic v0_q, v1_q;
	res_t d0_q, d1_q;
	logic push, pop;

	tcpsp_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg       (seg),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin       (fin)
	);

	tcpsp_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin       (fin),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res_d)
	);

	// two-entry output buffer: head drives the port, second entry is the skid
	assign res_ready = !v1_q;
	assign push      = res_valid && res_ready;
	assign pop       = v0_q && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (pop) begin
			if (v1_q) begin
				v1_q <= push;
			end else begin
				v0_q <= push;
			end
		end else if (push) begin
			if (v0_q) begin
				v1_q <= 1'b1;
			end else begin
				v0_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (v1_q) begin
				d0_q <= d1_q;
				if (push) begin
					d1_q <= res_d;
				end
			end else if (push) begin
				d0_q <= res_d;
			end
		end else if (push) begin
			if (v0_q) begin
				d1_q <= res_d;
			end else begin
				d0_q <= res_d;
			end
		end
	end

	assign res.valid             = v0_q;
	assign res.status            = d0_q.status;
	assign res.src_port          = d0_q.src_port;
	assign res.dst_port          = d0_q.dst_port;
	assign res.seq_num           = d0_q.seq_num;
	assign res.ack_num           = d0_q.ack_num;
	assign res.header_words      = d0_q.header_words;
	assign res.flag_bits         = d0_q.flag_bits;
	assign res.window            = d0_q.window;
	assign res.urgent_ptr        = d0_q.urgent_ptr;
	assign res.option_count      = d0_q.option_count;
	assign res.payload_length    = d0_q.payload_length;
	assign res.computed_checksum = d0_q.computed_checksum;

`ifndef NO_ASSERTIONS
	a_skid_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> v0_q)
		else $error("output skid entry held without a head entry");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status == ST_SHORT |->
			res.computed_checksum == 16'h0000 && res.src_port == 16'h0000 &&
			res.header_words == 4'd0)
		else $error("short segment result carries nonzero fields");

	a_err_no_opts: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != ST_OK |->
			res.option_count == 6'd0 && res.payload_length == 16'h0000)
		else $error("failed segment reports options or payload");

	a_ok_hdr_len: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status == ST_OK |-> res.header_words >= MIN_HDR_WORDS)
		else $error("accepted segment with header below minimum");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q && !res.ready |=> v1_q && v0_q)
		else $error("buffered result lost while stalled");
`endif

endmodule

>>> sv/tcpsp_walk.sv
// ----------------------------------------------------------------------------
// tcpsp_walk
// Input register and per-byte segment state: header capture, option walk
// and the running word sum. Hands a summary over at the last byte.
// ----------------------------------------------------------------------------
module tcpsp_walk
	import tcpsp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	tcpsp_seg_if.sink     seg,
	output logic          fin_valid,
	input  logic          fin_ready,
	output fin_t          fin
);

	logic      v_s1;
	seg_word_t w_s1;
	logic      take;

	// per-segment control state
	logic [15:0]       idx_q;
	logic [DSUM_W-1:0] dsum_q;
	logic [PSUM_W-1:0] psum_q;
	logic [7:0]        obl_q;
	logic              owl_q;
	logic [5:0]        ocnt_q;

	// captured header bytes
	logic [7:0]  hold_q;
	logic [31:0] port_q;
	logic [31:0] seq_q;
	logic [31:0] ack_q;
	logic [3:0]  hw_q;
	logic [7:0]  flags_q;
	logic [15:0] win_q;
	logic [15:0] urg_q;

	logic [15:0]       idx, idx_n;
	logic [DSUM_W-1:0] dsum, dsum_n;
	logic [PSUM_W-1:0] psum;
	logic [7:0]        obl, obl_n;
	logic              owl, owl_n;
	logic [5:0]        ocnt, ocnt_n;
	logic [7:0]        hold_n;
	logic [31:0]       port_n, seq_n, ack_n;
	logic [3:0]        hw_n;
	logic [7:0]        flags_n;
	logic [15:0]       win_n, urg_n;
	logic              taken;
	logic              opt_area;
	logic [7:0]        b;

	assign take      = v_s1 && (!w_s1.last_byte || fin_ready);
	assign seg.ready = !v_s1 || take;
	assign fin_valid = v_s1 && w_s1.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (seg.ready) begin
			v_s1 <= seg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seg.valid && seg.ready) begin
			w_s1.seg_byte   <= seg.seg_byte;
			w_s1.first_byte <= seg.first_byte;
			w_s1.last_byte  <= seg.last_byte;
			w_s1.src_ip     <= seg.src_ip;
			w_s1.dst_ip     <= seg.dst_ip;
		end
	end

	// a first mark starts from cleared state with the new addresses
	assign b    = w_s1.seg_byte;
	assign idx  = w_s1.first_byte ? '0 : idx_q;
	assign dsum = w_s1.first_byte ? '0 : dsum_q;
	assign obl  = w_s1.first_byte ? '0 : obl_q;
	assign owl  = w_s1.first_byte ? 1'b0 : owl_q;
	assign ocnt = w_s1.first_byte ? '0 : ocnt_q;
	assign psum = w_s1.first_byte ?
		PSUM_W'(w_s1.src_ip[31:16]) + PSUM_W'(w_s1.src_ip[15:0]) +
		PSUM_W'(w_s1.dst_ip[31:16]) + PSUM_W'(w_s1.dst_ip[15:0]) : psum_q;

	// bytes past the counter limit are dropped
	assign taken    = idx != MAX_COUNT;
	assign opt_area = taken && idx >= MIN_HDR_BYTES && idx < {10'd0, hw_q, 2'b00};

	always_comb begin
		idx_n   = taken ? idx + 16'd1 : idx;
		dsum_n  = dsum;
		hold_n  = hold_q;
		port_n  = port_q;
		seq_n   = seq_q;
		ack_n   = ack_q;
		hw_n    = hw_q;
		flags_n = flags_q;
		win_n   = win_q;
		urg_n   = urg_q;
		obl_n   = obl;
		owl_n   = owl;
		ocnt_n  = ocnt;
		if (taken) begin
			if (idx[0]) begin
				dsum_n = dsum + DSUM_W'({hold_q, b});
			end else begin
				hold_n = b;
			end
			case (idx)
				16'd0:   port_n[31:24] = b;
				16'd1:   port_n[23:16] = b;
				16'd2:   port_n[15:8]  = b;
				16'd3:   port_n[7:0]   = b;
				16'd4:   seq_n[31:24]  = b;
				16'd5:   seq_n[23:16]  = b;
				16'd6:   seq_n[15:8]   = b;
				16'd7:   seq_n[7:0]    = b;
				16'd8:   ack_n[31:24]  = b;
				16'd9:   ack_n[23:16]  = b;
				16'd10:  ack_n[15:8]   = b;
				16'd11:  ack_n[7:0]    = b;
				16'd12:  hw_n          = b[7:4];
				16'd13:  flags_n       = b;
				16'd14:  win_n[15:8]   = b;
				16'd15:  win_n[7:0]    = b;
				16'd18:  urg_n[15:8]   = b;
				16'd19:  urg_n[7:0]    = b;
				default: ;
			endcase
		end
		if (opt_area) begin
			if (owl) begin
				obl_n = (b < OPT_LEN_MIN) ? 8'd0 : b - OPT_LEN_MIN;
				owl_n = 1'b0;
			end else if (obl != 8'd0) begin
				obl_n = obl - 8'd1;
			end else begin
				if (ocnt != OPT_CNT_MAX) begin
					ocnt_n = ocnt + 6'd1;
				end
				// end of list and no-op carry no length byte
				if (b > 8'd1) begin
					owl_n = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			dsum_q <= '0;
			psum_q <= '0;
			obl_q  <= '0;
			owl_q  <= 1'b0;
			ocnt_q <= '0;
		end else if (take) begin
			if (w_s1.last_byte) begin
				idx_q  <= '0;
				dsum_q <= '0;
				psum_q <= '0;
				obl_q  <= '0;
				owl_q  <= 1'b0;
				ocnt_q <= '0;
			end else begin
				idx_q  <= idx_n;
				dsum_q <= dsum_n;
				psum_q <= psum;
				obl_q  <= obl_n;
				owl_q  <= owl_n;
				ocnt_q <= ocnt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hold_q  <= hold_n;
			port_q  <= port_n;
			seq_q   <= seq_n;
			ack_q   <= ack_n;
			hw_q    <= hw_n;
			flags_q <= flags_n;
			win_q   <= win_n;
			urg_q   <= urg_n;
		end
	end

	always_comb begin
		fin.n            = idx_n;
		fin.data_sum     = dsum_n;
		fin.pseudo_sum   = psum;
		fin.hold         = hold_n;
		fin.ports        = port_n;
		fin.seq_num      = seq_n;
		fin.ack_num      = ack_n;
		fin.header_words = hw_n;
		fin.flag_bits    = flags_n;
		fin.window       = win_n;
		fin.urgent_ptr   = urg_n;
		fin.option_count = ocnt_n;
	end

endmodule

>>> sv/tcpsp_finish.sv
// ----------------------------------------------------------------------------
// tcpsp_finish
// Two-stage result path: adds pseudo-header, tail and length to the word
// sum and grades the header, then folds the sum into the checksum.
// ----------------------------------------------------------------------------
module tcpsp_finish
	import tcpsp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic fin_valid,
	output logic fin_ready,
	input  fin_t fin,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	logic        v_s2, v_s3;
	fin_t        f_s2;
	res_t        r_s3;
	logic [31:0] total_s3;
	logic        short_s3;
	logic        rdy3;

	logic [15:0] tail;
	logic [17:0] extra;
	logic [31:0] total;
	logic [15:0] hw4;
	logic        short_seg, bad_hdr;
	res_t        r;
	logic [16:0] fold1;
	logic [15:0] fold2;

	assign rdy3      = !v_s3 || res_ready;
	assign fin_ready = !v_s2 || rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (fin_ready) begin
				v_s2 <= fin_valid;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// odd length: the held byte is the high half of a zero-padded word
	assign tail      = f_s2.n[0] ? {f_s2.hold, 8'h00} : 16'h0000;
	assign extra     = {2'b00, f_s2.n} + {2'b00, tail} + {10'd0, TCP_PROTO};
	assign total     = {1'b0, f_s2.data_sum} + 32'(f_s2.pseudo_sum) + 32'(extra);
	assign hw4       = {10'd0, f_s2.header_words, 2'b00};
	assign short_seg = f_s2.n < MIN_HDR_BYTES;
	assign bad_hdr   = f_s2.header_words < MIN_HDR_WORDS || hw4 > f_s2.n;

	always_comb begin
		r = '0;
		if (short_seg) begin
			r.status = ST_SHORT;
		end else begin
			r.status       = bad_hdr ? ST_BADHDR : ST_OK;
			r.src_port     = f_s2.ports[31:16];
			r.dst_port     = f_s2.ports[15:0];
			r.seq_num      = f_s2.seq_num;
			r.ack_num      = f_s2.ack_num;
			r.header_words = f_s2.header_words;
			r.flag_bits    = f_s2.flag_bits;
			r.window       = f_s2.window;
			r.urgent_ptr   = f_s2.urgent_ptr;
			if (!bad_hdr) begin
				r.option_count   = f_s2.option_count;
				r.payload_length = f_s2.n - hw4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_valid && fin_ready) begin
			f_s2 <= fin;
		end
		if (v_s2 && rdy3) begin
			r_s3     <= r;
			total_s3 <= total;
			short_s3 <= short_seg;
		end
	end

	// end-around carry fold; the total always holds the protocol word, so never 0
	assign fold1 = {1'b0, total_s3[31:16]} + {1'b0, total_s3[15:0]};
	assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

	always_comb begin
		res                   = r_s3;
		res.computed_checksum = short_s3 ? 16'h0000 : ~fold2;
	end

	assign res_valid = v_s3;

endmodule
